/* rtl/strict_priority_multi_queue_core_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_CORE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spmq_pkg.sv */
// Shared widths, codes and record type of the priority queue scheduler.
`default_nettype none

package spmq_pkg;

  // Field widths
  localparam int KindW   = 2;
  localparam int QiW     = 3;
  localparam int IdW     = 8;
  localparam int PrioW   = 8;
  localparam int TimeW   = 16;
  localparam int StatusW = 2;
  localparam int QiuW    = 2;

  // Configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [0:0] REG_QUEUES_IN_USE = 1'b0;

  // Default sizes
  localparam int DefaultSlots     = 4;
  localparam int DefaultNumQueues = 2;

  // Command kinds
  localparam logic [KindW-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KindW-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KindW-1:0] KIND_TICK = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_QUEUE = 2'd2;
  localparam logic [StatusW-1:0] ST_ALL_EMPTY = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0] time_rem;
    logic [PrioW-1:0] prio;
    logic [IdW-1:0]   id;
  } task_rec_t;

endpackage

`default_nettype wire

/* rtl/spmq_if.sv */
// Valid/ready channel interfaces: command beats in, result beats out.
`default_nettype none

interface spmq_cmd_if;
  import spmq_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [QiW-1:0]   queue_index;
  logic [IdW-1:0]   task_id;
  logic [PrioW-1:0] task_priority;
  logic [TimeW-1:0] task_time;

  modport source (output valid, kind, queue_index, task_id, task_priority, task_time,
                  input ready);
  modport sink   (input valid, kind, queue_index, task_id, task_priority, task_time,
                  output ready);
endinterface

interface spmq_res_if;
  import spmq_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     out_id;
  logic [PrioW-1:0]   out_priority;
  logic [TimeW-1:0]   out_time;

  modport source (output valid, status, out_id, out_priority, out_time, input ready);
  modport sink   (input valid, status, out_id, out_priority, out_time, output ready);
endinterface

`default_nettype wire

/* rtl/strict_priority_multi_queue_core.sv */
// Strict-priority multi-queue task scheduler: top level.
//
// Channels: cmd (sink) carries one command beat: kind (enqueue, dequeue,
// tick), queue_index and a task record. res (source) returns exactly one
// result beat per command: status plus the popped record on a good dequeue.
// APB port: one register, queues_in_use, at byte address 0; writing it
// empties every queue (slot contents are left in place). Write it only
// while no command is in flight.
// Result: registered, valid in the cycle after its command beat is taken.
// Throughput: one command per cycle while res takes results; the only
// stage is the result register, and all queue state (pointers, slots)
// updates at the accepting edge, so the next command sees it right away.
// Stall: while res is held off, the result register keeps its beat and
// cmd.ready drops; it rises again in the cycle the result is taken.
// Reset (rst, synchronous): queues_in_use = 0, all pointers zero, no result
// pending. Slot contents are not cleared; a slot is never popped before an
// enqueue writes it.
`default_nettype none

module strict_priority_multi_queue_core #(
  parameter int SLOTS       = spmq_pkg::DefaultSlots,
  parameter int QUEUE_COUNT = spmq_pkg::DefaultNumQueues
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spmq_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [spmq_pkg::ApbDataW-1:0] pwdata,
  output logic      [spmq_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  // Streams
  spmq_cmd_if.sink                           cmd,
  spmq_res_if.source                         res
);
  import spmq_pkg::*;
  `include "strict_priority_multi_queue_core_defines.svh"

  localparam int PW = $clog2(SLOTS);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  // Largest value queues_in_use may take (it is only two bits wide)
  localparam logic [QiuW-1:0] QiuCap = QiuW'((QUEUE_COUNT > 3) ? 3 : QUEUE_COUNT);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    if (p == PW'(SLOTS - 1)) return '0;
    else return p + PW'(1);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [QiuW-1:0] queues_in_use;
  logic [QiuW-1:0] qiu_wr_val;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ApbAddrW-1:2] == REG_QUEUES_IN_USE);
  // Only the low QiuW bits of pwdata count; larger values clamp to QiuCap
  assign qiu_wr_val = (pwdata[QiuW-1:0] > QiuCap) ? QiuCap : pwdata[QiuW-1:0];
  assign prdata = (paddr[ApbAddrW-1:2] == REG_QUEUES_IN_USE) ?
                  {{(ApbDataW-QiuW){1'b0}}, queues_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= '0;
    end else if (cfg_wr) begin
      queues_in_use <= qiu_wr_val;
    end
  end

  // ---------------------------------------------------------------------
  // Queue state
  // ---------------------------------------------------------------------
  logic [PW-1:0] head [QUEUE_COUNT];
  logic [PW-1:0] tail [QUEUE_COUNT];
  task_rec_t     slots [QUEUE_COUNT][SLOTS];

  logic          cmd_acc;
  logic [QW-1:0] qsel;        // enqueue target
  logic          qi_ok;       // enqueue target is in use
  logic          q_full;      // enqueue target has no free slot
  logic          enq_do;
  logic [QW-1:0] pick;        // dequeue winner
  logic          found;
  logic          deq_do;
  logic          tick_do;
  logic          ptrs_zero;
  logic [QUEUE_COUNT-1:0] in_use;

  logic [StatusW-1:0] status_next;
  task_rec_t          rec_next;

  assign cmd.ready = !res.valid || res.ready;
  assign cmd_acc   = cmd.valid && cmd.ready;

  always_comb begin
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      in_use[q] = ({1'b0, queues_in_use} > 3'(q));
    end
  end

  assign qsel   = cmd.queue_index[QW-1:0];
  assign qi_ok  = cmd.queue_index < {1'b0, queues_in_use};
  assign q_full = (ring_next(tail[qsel]) == head[qsel]);

  // Lowest-numbered non-empty queue in use wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      if (!found && in_use[q] && (head[q] != tail[q])) begin
        found = 1'b1;
        pick  = QW'(q);
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    rec_next    = '0;
    enq_do      = 1'b0;
    deq_do      = 1'b0;
    tick_do     = 1'b0;
    unique case (cmd.kind)
      KIND_ENQ: begin
        if (!qi_ok) begin
          status_next = ST_BAD_QUEUE;
        end else if (q_full) begin
          status_next = ST_FULL;
        end else begin
          enq_do = cmd_acc;
        end
      end
      KIND_DEQ: begin
        if (found) begin
          rec_next = slots[pick][head[pick]];
          deq_do   = cmd_acc;
        end else begin
          status_next = ST_ALL_EMPTY;
        end
      end
      KIND_TICK: begin
        tick_do = cmd_acc;
      end
      default: begin
        // unused kind: no effect, status ok
      end
    endcase
  end

  // Pointers; a register write clears all rings (user: idle only, unchecked)
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
      end
    end else begin
      if (enq_do) begin
        tail[qsel] <= ring_next(tail[qsel]);
      end
      if (deq_do) begin
        head[pick] <= ring_next(head[pick]);
      end
    end
  end

  // Slot contents: enqueue writes at the tail, tick ages every slot in use
  always_ff @(posedge clk) begin
    if (enq_do) begin
      slots[qsel][tail[qsel]] <= '{time_rem: cmd.task_time,
                                   prio:     cmd.task_priority,
                                   id:       cmd.task_id};
    end
    if (tick_do) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (in_use[q] && (slots[q][s].time_rem != '0)) begin
            slots[q][s].time_rem <= slots[q][s].time_rem - TimeW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    ptrs_zero = 1'b1;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      if ((head[q] != '0) || (tail[q] != '0)) ptrs_zero = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.ready) begin
      res.valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      res.status       <= status_next;
      res.out_id       <= rec_next.id;
      res.out_priority <= rec_next.prio;
      res.out_time     <= rec_next.time_rem;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `SPMQ_ASSERT_NEXT(a_beat_yields_result, clk, rst, cmd_acc, res.valid,
    "accepted command beat produced no result")
  `SPMQ_ASSERT_NEXT(a_cfg_clears_ptrs, clk, rst, cfg_wr, ptrs_zero,
    "register write did not empty the queues")
  `SPMQ_ASSERT_NOW(a_qiu_in_range, clk, rst, 1'b1, queues_in_use <= QiuCap,
    "queues_in_use above number of queues")
  `SPMQ_ASSERT_NOW(a_data_zero_unless_pop, clk, rst, res.valid && (res.status != ST_OK),
    (res.out_id == '0) && (res.out_priority == '0) && (res.out_time == '0),
    "record data on a result that is not a pop")

endmodule

`default_nettype wire

/* test/strict_priority_multi_queue_core_test.sv */
// Self-checking testbench for the strict-priority multi-queue scheduler core.
`default_nettype none

module strict_priority_multi_queue_core_test;
  import spmq_pkg::*;

  // Block sizes as built by default
  localparam int SLOTS = DefaultSlots;
  localparam int NQ    = DefaultNumQueues;

  // Kind code that the block does not define; must be a no-op answering ok
  localparam logic [KindW-1:0] KIND_RSVD = 2'd3;

  // Register map: queues_in_use at byte 0, the next word is unmapped
  localparam logic [ApbAddrW-1:0] QIU_ADDR      = {REG_QUEUES_IN_USE, 2'b00};
  localparam logic [ApbAddrW-1:0] UNMAPPED_ADDR = {~REG_QUEUES_IN_USE, 2'b00};

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [QiW-1:0]   qi;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] tm;
  } sched_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [PrioW-1:0]   prio;
    logic [TimeW-1:0]   tm;
  } sched_res_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  wire  [ApbDataW-1:0] prdata;
  wire                 pready;

  spmq_cmd_if cmd_ch ();
  spmq_res_if res_ch ();

  strict_priority_multi_queue_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .res     (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow: ring pointers, slot records and the queue count.
  // Slots keep their contents across a pointer clear, as in the block.
  // ---------------------------------------------------------------------------
  task_rec_t  slot_mem [NQ*SLOTS];
  int         head_q [NQ];
  int         tail_q [NQ];
  int         qiu_model;
  sched_res_t expected_results [$];

  // Run bookkeeping
  int  fails;
  int  n_cmds;
  int  n_results;
  int  n_popped;
  int  n_full;
  int  n_bad;
  int  n_writes;
  bit  src_gaps;
  bit  sink_stalls;
  int  sink_hold_len;

  function automatic sched_res_t schedule_cmd(input sched_cmd_t c);
    sched_res_t r;
    bit         found;
    r     = '0;
    found = 1'b0;
    case (c.kind)
      KIND_ENQ: begin
        if (int'(c.qi) >= qiu_model || int'(c.qi) >= NQ) begin
          r.status = ST_BAD_QUEUE;
        end else if ((tail_q[c.qi] + 1) % SLOTS == head_q[c.qi]) begin
          // one slot always stays empty, so SLOTS-1 records fill a ring
          r.status = ST_FULL;
        end else begin
          slot_mem[int'(c.qi)*SLOTS + tail_q[c.qi]] = '{time_rem: c.tm, prio: c.prio, id: c.id};
          tail_q[c.qi] = (tail_q[c.qi] + 1) % SLOTS;
        end
      end
      KIND_DEQ: begin
        // lowest-numbered non-empty queue wins
        for (int q = 0; q < qiu_model && q < NQ; q++) begin
          if (!found && head_q[q] != tail_q[q]) begin
            r.id   = slot_mem[q*SLOTS + head_q[q]].id;
            r.prio = slot_mem[q*SLOTS + head_q[q]].prio;
            r.tm   = slot_mem[q*SLOTS + head_q[q]].time_rem;
            head_q[q] = (head_q[q] + 1) % SLOTS;
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_ALL_EMPTY;
      end
      KIND_TICK: begin
        // every slot of a queue in use, live or not; stops at zero
        for (int q = 0; q < qiu_model && q < NQ; q++) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_mem[q*SLOTS + s].time_rem != '0)
              slot_mem[q*SLOTS + s].time_rem = slot_mem[q*SLOTS + s].time_rem - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a run still going at this point is reported as a failure.
  initial begin
    #800000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall driver. Long holds are counted here; short random
  // stalls come in bursts while sink_stalls is set.
  // ---------------------------------------------------------------------------
  initial begin : res_throttle
    int n;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        res_ch.ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
        res_ch.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Every result beat is matched against the oldest pending expectation.
  always @(posedge clk) begin : check_results
    sched_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: status=%0d", res_ch.status);
        fails++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        if (want.status == ST_OK && want.id != 0) n_popped++;
        if (want.status == ST_FULL)      n_full++;
        if (want.status == ST_BAD_QUEUE) n_bad++;
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fails++;
        end
        if (res_ch.out_id !== want.id) begin
          $error("out_id: expected %0d, got %0d", want.id, res_ch.out_id);
          fails++;
        end
        if (res_ch.out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, res_ch.out_priority);
          fails++;
        end
        if (res_ch.out_time !== want.tm) begin
          $error("out_time: expected %0d, got %0d", want.tm, res_ch.out_time);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offers one command beat and returns at the edge it is taken. valid stays
  // high on return so back-to-back beats need no second assignment.
  task automatic push_cmd(input sched_cmd_t c);
    int gap;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.kind          <= c.kind;
    cmd_ch.queue_index   <= c.qi;
    cmd_ch.task_id       <= c.id;
    cmd_ch.task_priority <= c.prio;
    cmd_ch.task_time     <= c.tm;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_results.push_back(schedule_cmd(c));
    n_cmds++;
  endtask

  task automatic push_op(input logic [KindW-1:0] kind, input int qi,
                         input int id, input int prio, input int tm);
    sched_cmd_t c;
    c.kind = kind;
    c.qi   = qi[QiW-1:0];
    c.id   = id[IdW-1:0];
    c.prio = prio[PrioW-1:0];
    c.tm   = tm[TimeW-1:0];
    push_cmd(c);
  endtask

  // Drops valid, waits for the pipe to drain, then does one APB write.
  // The result register is the only stage.
  // A write to the count register is read back on the following cycle.
  task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    int v;
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == QIU_ADDR) begin
      v = int'(data[QiuW-1:0]);
      qiu_model = (v > NQ) ? NQ : v;
      for (int q = 0; q < NQ; q++) begin
        head_q[q] = 0;
        tail_q[q] = 0;
      end
      @(posedge clk);
      if (prdata !== ApbDataW'(qiu_model)) begin
        $error("prdata: expected %0d, got %0d", qiu_model, prdata);
        fails++;
      end
    end
    n_writes++;
  endtask

  // Mix tilted toward enqueue so rings fill and the full case shows up;
  // short times let ticks drive records down to zero.
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      c.kind = KIND_ENQ;
    else if (roll < 78) c.kind = KIND_DEQ;
    else if (roll < 95) c.kind = KIND_TICK;
    else                c.kind = KIND_RSVD;
    if (qiu_model > 0 && $urandom_range(0, 99) < 85)
      c.qi = QiW'($urandom_range(0, qiu_model - 1));
    else
      c.qi = QiW'($urandom_range(0, 7));
    c.id   = IdW'($urandom_range(0, 255));
    c.prio = PrioW'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) c.tm = TimeW'($urandom_range(0, 3));
    else                           c.tm = TimeW'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) push_cmd(random_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset no queue is set up: enqueues bounce, dequeues find nothing.
  task automatic test_reset_state();
    push_op(KIND_ENQ, 0, 8'h11, 8'h22, 16'h3333);
    push_op(KIND_DEQ, 0, 0, 0, 0);
    push_op(KIND_TICK, 0, 0, 0, 0);
    push_op(KIND_RSVD, 7, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  // Field extremes, full ring, bad index, tick saturation, priority order.
  task automatic test_queue_ops();
    write_reg(QIU_ADDR, 32'd2);
    push_op(KIND_ENQ, 1, 8'h5A, 8'hA5, 16'h8000);
    push_op(KIND_ENQ, 0, 8'h00, 8'h00, 16'h0000);
    push_op(KIND_ENQ, 0, 8'hFF, 8'hFF, 16'hFFFF);
    push_op(KIND_ENQ, 0, 8'h01, 8'h80, 16'h0001);
    push_op(KIND_ENQ, 0, 8'h77, 8'h77, 16'h7777);   // ring full
    push_op(KIND_ENQ, 2, 8'h12, 8'h34, 16'h5678);   // first index past the count
    push_op(KIND_ENQ, 7, 8'h12, 8'h34, 16'h5678);
    push_op(KIND_TICK, 5, 8'hFF, 8'hFF, 16'hFFFF);  // zero time stays zero
    for (int i = 0; i < 5; i++) push_op(KIND_DEQ, 1, 0, 0, 0);
    push_op(KIND_RSVD, 0, 8'h12, 8'h34, 16'h5678);
  endtask

  // Count above the queue total saturates; only the low bits of pwdata count;
  // an unmapped address leaves the pointers alone.
  task automatic test_register();
    write_reg(QIU_ADDR, 32'd3);
    push_op(KIND_ENQ, 1, 8'hC3, 8'h3C, 16'h0002);
    push_op(KIND_DEQ, 0, 0, 0, 0);
    write_reg(QIU_ADDR, 32'hFFFF_FFFD);              // low bits give one queue
    push_op(KIND_ENQ, 1, 8'h99, 8'h99, 16'h9999);
    push_op(KIND_ENQ, 0, 8'hE1, 8'h1E, 16'h0100);
    push_op(KIND_TICK, 0, 0, 0, 0);
    write_reg(UNMAPPED_ADDR, 32'd0);
    push_op(KIND_DEQ, 0, 0, 0, 0);
  endtask

  // Random traffic across several queue counts, gaps and stalls on.
  task automatic test_random_settings();
    write_reg(QIU_ADDR, 32'd2);
    run_random(230);
    write_reg(QIU_ADDR, 32'd1);
    run_random(130);
    write_reg(QIU_ADDR, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b11});
    run_random(130);
    write_reg(QIU_ADDR, 32'd0);
    run_random(40);
  endtask

  // Sink holds off for a long stretch; the single result slot fills and the
  // command side must stall until the hold ends.
  task automatic test_backpressure();
    write_reg(QIU_ADDR, 32'd2);
    src_gaps = 1'b0;
    sink_hold_len = 60;
    run_random(20);
    src_gaps = 1'b1;
  endtask

  // Full rate: no gaps, no stalls, to the end of the run.
  task automatic test_full_rate();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    run_random(150);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int waited;
    fails = 0;  n_cmds = 0;  n_results = 0;  n_popped = 0;
    n_full = 0; n_bad = 0;   n_writes = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    sink_hold_len = 0;
    qiu_model = 0;
    for (int q = 0; q < NQ; q++) begin
      head_q[q] = 0;
      tail_q[q] = 0;
    end
    for (int i = 0; i < NQ*SLOTS; i++) slot_mem[i] = '0;

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.kind          = KIND_ENQ;
    cmd_ch.queue_index   = '0;
    cmd_ch.task_id       = '0;
    cmd_ch.task_priority = '0;
    cmd_ch.task_time     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_queue_ops();
    test_register();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    // Drain: wait for every pending result, bounded.
    cmd_ch.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fails++;
    end
    repeat (5) @(posedge clk);

    $display("tb: %0d commands, %0d register writes, %0d results checked",
             n_cmds, n_writes, n_results);
    $display("tb: %0d nonzero records popped, %0d full rejects, %0d bad-index rejects",
             n_popped, n_full, n_bad);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
